// ===== rtl/lphm_pkg.sv =====
// lphm_pkg: shared types and codes for the linear probing hash map
`timescale 1ns / 1ps
package lphm_pkg;

  localparam int CMD_W    = 3;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;
  localparam int MARK_W   = 2;

  localparam logic [CMD_W-1:0] CMD_FIND   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_ALIVE = 2'd1;
  localparam logic [MARK_W-1:0] MARK_DEAD  = 2'd2;

  typedef struct packed {
    logic [MARK_W-1:0] mark;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } slot_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } pair_t;

endpackage

// ===== rtl/lphm_in_if.sv =====
// lphm_in_if: request channel of the hash map
`timescale 1ns / 1ps
interface lphm_in_if;
  logic                        valid;
  logic                        ready;
  logic [lphm_pkg::CMD_W-1:0]  command;
  logic [lphm_pkg::KEY_W-1:0]  key;
  logic [lphm_pkg::VAL_W-1:0]  value;

  modport source (output valid, command, key, value, input ready);
  modport sink   (input valid, command, key, value, output ready);
endinterface

// ===== rtl/lphm_out_if.sv =====
// lphm_out_if: result channel of the hash map
`timescale 1ns / 1ps
interface lphm_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [lphm_pkg::VAL_W-1:0]     value_out;
  logic [lphm_pkg::STATUS_W-1:0]  status;
  logic [lphm_pkg::COUNT_W-1:0]   entries_alive;

  modport source (output valid, found, value_out, status, entries_alive, input ready);
  modport sink   (input valid, found, value_out, status, entries_alive, output ready);
endinterface

// ===== rtl/linear_probe_hash_map.sv =====
// linear_probe_hash_map: open addressing key/value map with linear probing
//
//   channel  dir  fields
//   in_ch    in   command, key, value
//   out_ch   out  found, value_out, status, entries_alive
//
// a lookup reads each probed slot in turn from the slot memory, then posts the result
// clear empties every slot; a purge scans every slot, then probes again for each live entry
// after reset the slot table is swept empty before the first request is taken
// a stalled result holds in the output register; a new request is taken meanwhile
`timescale 1ns / 1ps
module linear_probe_hash_map #(
  parameter int SLOTS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  lphm_in_if.sink    in_ch,
  lphm_out_if.source out_ch
);

  localparam int IW   = $clog2(SLOTS);
  localparam int TW   = $clog2(SLOTS / 2);
  localparam int TCW  = TW + 1;
  localparam int AW   = $clog2(SLOTS / 2 + 1);
  localparam int SW   = IW + 1;
  localparam int HALF = SLOTS / 2;

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_PROBE, S_SCAN, S_LOAD, S_LOAD2, S_RESP
  } state_t;

  typedef enum logic [1:0] {M_CMD, M_REINS, M_AFTER} mode_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;

  logic [lphm_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [lphm_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [lphm_pkg::VAL_W-1:0]    dv_r, dv_nxt;
  logic [lphm_pkg::KEY_W-1:0]    pkey_r, pkey_nxt;
  logic [lphm_pkg::VAL_W-1:0]    pval_r, pval_nxt;
  logic [IW-1:0]                 raddr_r, raddr_nxt;
  logic [IW-1:0]                 eaddr_r, eaddr_nxt;
  logic                          rv_r, rv_nxt;
  logic [SW-1:0]                 steps_r, steps_nxt;
  logic                          init_r, init_nxt;
  logic [AW-1:0]                 alive_r, alive_nxt;
  logic [AW-1:0]                 used_r, used_nxt;
  logic [TCW-1:0]                tcnt_r, tcnt_nxt;
  logic [TCW-1:0]                tj_r, tj_nxt;
  logic                          res_found_r, res_found_nxt;
  logic [lphm_pkg::VAL_W-1:0]    res_vo_r, res_vo_nxt;
  logic [lphm_pkg::STATUS_W-1:0] res_st_r, res_st_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r, out_found_nxt;
  logic [lphm_pkg::VAL_W-1:0]    out_vo_r, out_vo_nxt;
  logic [lphm_pkg::STATUS_W-1:0] out_st_r, out_st_nxt;
  logic [lphm_pkg::COUNT_W-1:0]  out_alive_r, out_alive_nxt;

  lphm_pkg::slot_t mem [SLOTS];
  lphm_pkg::slot_t rdata_r;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  lphm_pkg::slot_t mem_wdata;

  lphm_pkg::pair_t tmp_mem [HALF];
  lphm_pkg::pair_t tmp_rd_r;
  logic            tmp_we;
  logic [TW-1:0]   tmp_waddr;
  lphm_pkg::pair_t tmp_wdata;

  logic                      hit_empty, hit_key, alive_hit, last_step, full_now;
  logic [TCW-1:0]            tcnt_inc;
  logic [lphm_pkg::COUNT_W+AW-1:0] alive_ext;

  assign alive_ext = {{lphm_pkg::COUNT_W{1'b0}}, alive_r};

  assign hit_empty = (rdata_r.mark == lphm_pkg::MARK_EMPTY);
  assign hit_key   = !hit_empty && (rdata_r.key == pkey_r);
  assign alive_hit = hit_key && (rdata_r.mark == lphm_pkg::MARK_ALIVE);
  assign last_step = (steps_r == SW'(SLOTS - 1));
  assign full_now  = (used_r >= AW'(HALF));
  assign tcnt_inc  = tcnt_r + TCW'(1);

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.value_out     = out_vo_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.entries_alive = out_alive_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    dv_nxt        = dv_r;
    pkey_nxt      = pkey_r;
    pval_nxt      = pval_r;
    raddr_nxt     = raddr_r;
    eaddr_nxt     = eaddr_r;
    rv_nxt        = rv_r;
    steps_nxt     = steps_r;
    init_nxt      = init_r;
    alive_nxt     = alive_r;
    used_nxt      = used_r;
    tcnt_nxt      = tcnt_r;
    tj_nxt        = tj_r;
    res_found_nxt = res_found_r;
    res_vo_nxt    = res_vo_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_vo_nxt    = out_vo_r;
    out_st_nxt    = out_st_r;
    out_alive_nxt = out_alive_r;
    mem_we        = 1'b0;
    mem_waddr     = eaddr_r;
    mem_wdata     = '{mark: lphm_pkg::MARK_EMPTY, key: rdata_r.key, value: rdata_r.value};
    tmp_we        = 1'b0;
    tmp_waddr     = tcnt_r[TW-1:0];
    tmp_wdata     = '{key: rdata_r.key, value: rdata_r.value};

    case (state_r)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = raddr_r;
        raddr_nxt = raddr_r + IW'(1);
        if (raddr_r == IW'(SLOTS - 1)) begin
          alive_nxt = '0;
          used_nxt  = '0;
          init_nxt  = 1'b0;
          state_nxt = init_r ? S_IDLE : S_RESP;
        end
      end

      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt       = in_ch.command;
          key_nxt       = in_ch.key;
          pkey_nxt      = in_ch.key;
          dv_nxt        = (in_ch.command == lphm_pkg::CMD_INSERT) ? in_ch.value : '0;
          pval_nxt      = (in_ch.command == lphm_pkg::CMD_INSERT) ? in_ch.value : '0;
          mode_nxt      = M_CMD;
          res_found_nxt = 1'b0;
          res_vo_nxt    = '0;
          res_st_nxt    = lphm_pkg::ST_OK;
          raddr_nxt     = in_ch.key[IW-1:0];
          rv_nxt        = 1'b0;
          steps_nxt     = '0;
          case (in_ch.command)
            lphm_pkg::CMD_FIND, lphm_pkg::CMD_INSERT,
            lphm_pkg::CMD_ERASE, lphm_pkg::CMD_GET: state_nxt = S_PROBE;
            lphm_pkg::CMD_CLEAR: begin
              raddr_nxt = '0;
              state_nxt = S_SWEEP;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end

      S_PROBE: begin
        // reads stream ahead one slot a cycle; surplus reads are dropped
        raddr_nxt = raddr_r + IW'(1);
        eaddr_nxt = raddr_r;
        rv_nxt    = 1'b1;
        if (rv_r) begin
          steps_nxt = steps_r + SW'(1);
          if (hit_empty || hit_key || last_step) begin
            rv_nxt = 1'b0;
            if (mode_r == M_REINS) begin
              if (hit_empty) begin
                mem_we    = 1'b1;
                mem_wdata = '{mark: lphm_pkg::MARK_ALIVE, key: pkey_r, value: pval_r};
                alive_nxt = alive_r + AW'(1);
                used_nxt  = used_r + AW'(1);
              end
              tj_nxt = tj_r + TCW'(1);
              if (tj_r + TCW'(1) == tcnt_r) begin
                mode_nxt  = M_AFTER;
                pkey_nxt  = key_r;
                pval_nxt  = dv_r;
                raddr_nxt = key_r[IW-1:0];
                steps_nxt = '0;
                state_nxt = S_PROBE;
              end else begin
                state_nxt = S_LOAD;
              end
            end else begin
              state_nxt = S_RESP;
              case (cmd_r)
                lphm_pkg::CMD_FIND: begin
                  if (alive_hit) begin
                    res_found_nxt = 1'b1;
                    res_vo_nxt    = rdata_r.value;
                  end else begin
                    res_st_nxt = lphm_pkg::ST_ABSENT;
                  end
                end
                lphm_pkg::CMD_ERASE: begin
                  if (alive_hit) begin
                    mem_we        = 1'b1;
                    mem_wdata     = '{mark: lphm_pkg::MARK_DEAD, key: rdata_r.key,
                                      value: rdata_r.value};
                    res_found_nxt = 1'b1;
                    if (alive_r != '0) alive_nxt = alive_r - AW'(1);
                  end else begin
                    res_st_nxt = lphm_pkg::ST_ABSENT;
                  end
                end
                lphm_pkg::CMD_INSERT, lphm_pkg::CMD_GET: begin
                  if (alive_hit) begin
                    res_found_nxt = 1'b1;
                    res_vo_nxt    = rdata_r.value;
                  end else if (hit_key) begin
                    // tombstone with the same key comes back to life
                    mem_we     = 1'b1;
                    mem_wdata  = '{mark: lphm_pkg::MARK_ALIVE, key: pkey_r, value: pval_r};
                    alive_nxt  = alive_r + AW'(1);
                    res_vo_nxt = pval_r;
                  end else if (mode_r == M_CMD && full_now) begin
                    raddr_nxt = '0;
                    steps_nxt = '0;
                    tcnt_nxt  = '0;
                    state_nxt = S_SCAN;
                  end else if (full_now || !hit_empty) begin
                    res_st_nxt = lphm_pkg::ST_FULL;
                  end else begin
                    mem_we     = 1'b1;
                    mem_wdata  = '{mark: lphm_pkg::MARK_ALIVE, key: pkey_r, value: pval_r};
                    alive_nxt  = alive_r + AW'(1);
                    used_nxt   = used_r + AW'(1);
                    res_vo_nxt = pval_r;
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end

      S_SCAN: begin
        // copy live entries aside and empty every slot
        raddr_nxt = raddr_r + IW'(1);
        eaddr_nxt = raddr_r;
        rv_nxt    = 1'b1;
        if (rv_r) begin
          mem_we = 1'b1;
          if (rdata_r.mark == lphm_pkg::MARK_ALIVE) begin
            tmp_we   = 1'b1;
            tcnt_nxt = tcnt_inc;
          end
          if (eaddr_r == IW'(SLOTS - 1)) begin
            rv_nxt    = 1'b0;
            used_nxt  = '0;
            alive_nxt = '0;
            tj_nxt    = '0;
            if (tcnt_nxt == '0) begin
              mode_nxt  = M_AFTER;
              raddr_nxt = key_r[IW-1:0];
              steps_nxt = '0;
              state_nxt = S_PROBE;
            end else begin
              state_nxt = S_LOAD;
            end
          end
        end
      end

      S_LOAD: state_nxt = S_LOAD2;

      S_LOAD2: begin
        pkey_nxt  = tmp_rd_r.key;
        pval_nxt  = tmp_rd_r.value;
        mode_nxt  = M_REINS;
        raddr_nxt = tmp_rd_r.key[IW-1:0];
        rv_nxt    = 1'b0;
        steps_nxt = '0;
        state_nxt = S_PROBE;
      end

      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_vo_nxt    = res_vo_r;
          out_st_nxt    = res_st_r;
          out_alive_nxt = alive_ext[lphm_pkg::COUNT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[raddr_r];
  end

  always_ff @(posedge clk) begin
    if (tmp_we) tmp_mem[tmp_waddr] <= tmp_wdata;
    tmp_rd_r <= tmp_mem[tj_r[TW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      mode_r      <= M_CMD;
      raddr_r     <= '0;
      rv_r        <= 1'b0;
      steps_r     <= '0;
      init_r      <= 1'b1;
      alive_r     <= '0;
      used_r      <= '0;
      tcnt_r      <= '0;
      tj_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      raddr_r     <= raddr_nxt;
      rv_r        <= rv_nxt;
      steps_r     <= steps_nxt;
      init_r      <= init_nxt;
      alive_r     <= alive_nxt;
      used_r      <= used_nxt;
      tcnt_r      <= tcnt_nxt;
      tj_r        <= tj_nxt;
      out_valid_r <= out_valid_nxt;
      cmd_r       <= cmd_nxt;
      key_r       <= key_nxt;
      dv_r        <= dv_nxt;
      pkey_r      <= pkey_nxt;
      pval_r      <= pval_nxt;
      eaddr_r     <= eaddr_nxt;
      res_found_r <= res_found_nxt;
      res_vo_r    <= res_vo_nxt;
      res_st_r    <= res_st_nxt;
      out_found_r <= out_found_nxt;
      out_vo_r    <= out_vo_nxt;
      out_st_r    <= out_st_nxt;
      out_alive_r <= out_alive_nxt;
    end
  end

  // used slots never pass half the table
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n) used_r <= AW'(HALF))
    else $error("used slot count above half capacity");

  a_alive_le_used: assert property (@(posedge clk) disable iff (!rst_n) alive_r <= used_r)
    else $error("alive count above used count");

  a_tmp_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tmp_we |-> (state_r == S_SCAN))
    else $error("side buffer written outside purge scan");

  a_resp_posts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && (!out_valid_r || out_ch.ready)) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not posted");

endmodule
